// File: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is high
`define SSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define SSR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ssr_pkg.sv
// shared constants, types and codes of the segment reassembler
`timescale 1ns / 1ps

package ssr_pkg;

   // packet geometry
   localparam int SEGMENTS          = 32;
   localparam int IDX_W             = $clog2(SEGMENTS);
   localparam int CNT_W             = IDX_W;
   localparam int SWEEP_W           = IDX_W + 1;
   localparam int WIDE_W            = 9;

   // transaction field widths
   localparam int KIND_W            = 2;
   localparam int ID_W              = 4;
   localparam int SEQ_W             = 8;
   localparam int BYTE_W            = 8;
   localparam int BYTES_PER_SEGMENT = 4;
   localparam int WORD_W            = BYTE_W * BYTES_PER_SEGMENT;
   localparam int WIX_W             = 5;
   localparam int CODE_W            = 8;

   localparam logic [CODE_W-1:0] FAIL_CODE = CODE_W'(8'hFF);

   // request kinds on the input channel
   localparam logic [KIND_W-1:0] KIND_SEGMENT = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_READ    = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_RELEASE = KIND_W'(2);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_SEGMENT,
      OP_READ,
      OP_RELEASE,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [ID_W-1:0]    requester;
      logic [SEQ_W-1:0]   seq;
      logic [WORD_W-1:0]  word;
      logic [WIX_W-1:0]   word_index;
   } cmd_type;

endpackage

// File: design/ssr_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface ssr_req_if;
   logic                          valid;
   logic                          ready;
   logic [ssr_pkg::KIND_W-1:0]    kind;
   logic [ssr_pkg::ID_W-1:0]      requester;
   logic [ssr_pkg::SEQ_W-1:0]     seq;
   logic [ssr_pkg::BYTE_W-1:0]    byte0;
   logic [ssr_pkg::BYTE_W-1:0]    byte1;
   logic [ssr_pkg::BYTE_W-1:0]    byte2;
   logic [ssr_pkg::BYTE_W-1:0]    byte3;
   logic [ssr_pkg::WIX_W-1:0]     word_index;

   modport source (
      output valid, kind, requester, seq, byte0, byte1, byte2, byte3, word_index,
      input  ready
   );
   modport sink (
      input  valid, kind, requester, seq, byte0, byte1, byte2, byte3, word_index,
      output ready
   );
endinterface

interface ssr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          respond;
   logic [ssr_pkg::ID_W-1:0]      responder_id;
   logic [ssr_pkg::CODE_W-1:0]    resp_code;
   logic                          receiving;
   logic                          buffer_full;
   logic [ssr_pkg::WORD_W-1:0]    read_word;

   modport source (
      output valid, respond, responder_id, resp_code, receiving, buffer_full, read_word,
      input  ready
   );
   modport sink (
      input  valid, respond, responder_id, resp_code, receiving, buffer_full, read_word,
      output ready
   );
endinterface

// File: design/ssr_front.sv
// front stage: takes request transactions and turns them into commands
`timescale 1ns / 1ps

module ssr_front (
   input  logic             clock,
   input  logic             reset,
   ssr_req_if.sink          req_if,
   output logic             cmd_valid,
   output ssr_pkg::cmd_type cmd,
   input  logic             cmd_ready
);

   logic             valid_ff;
   logic             valid_in;
   ssr_pkg::cmd_type cmd_ff;
   ssr_pkg::cmd_type cmd_in;
   ssr_pkg::op_type  op;
   logic             take;

   // stage is free when empty or draining this cycle
   assign req_if.ready = !valid_ff || cmd_ready;
   assign take         = req_if.valid && req_if.ready;

   // classify the request kind
   always_comb begin
      unique case (req_if.kind)
         ssr_pkg::KIND_SEGMENT: op = ssr_pkg::OP_SEGMENT;
         ssr_pkg::KIND_READ:    op = ssr_pkg::OP_READ;
         ssr_pkg::KIND_RELEASE: op = ssr_pkg::OP_RELEASE;
         default:               op = ssr_pkg::OP_NOP;
      endcase
   end

   // pack the payload bytes into one word, byte0 lowest
   always_comb begin
      cmd_in.op         = op;
      cmd_in.requester  = req_if.requester;
      cmd_in.seq        = req_if.seq;
      cmd_in.word       = {req_if.byte3, req_if.byte2, req_if.byte1, req_if.byte0};
      cmd_in.word_index = req_if.word_index;
   end

   assign valid_in = take || (valid_ff && !cmd_ready);

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// File: design/ssr_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module ssr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ssr_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ssr_pkg::cmd_type pop_data
);

   localparam logic [ssr_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      ssr_pkg::QUEUE_PTR_W'(ssr_pkg::QUEUE_DEPTH - 1);
   localparam logic [ssr_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      ssr_pkg::QUEUE_CNT_W'(ssr_pkg::QUEUE_DEPTH);

   ssr_pkg::cmd_type                  entry_ff [ssr_pkg::QUEUE_DEPTH];
   logic [ssr_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [ssr_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [ssr_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic [ssr_pkg::QUEUE_CNT_W-1:0]   count_in;
   logic                              push;
   logic                              pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/ssr_back.sv
// back stage: segment rules, buffers, copy sweep and response register
`timescale 1ns / 1ps

module ssr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ssr_pkg::cmd_type cmd,
   ssr_rsp_if.source        rsp_if
);

   localparam logic [ssr_pkg::SWEEP_W-1:0] SWEEP_END =
      ssr_pkg::SWEEP_W'(ssr_pkg::SEGMENTS);
   localparam logic [ssr_pkg::WIDE_W-1:0]  LAST_SEQ  =
      ssr_pkg::WIDE_W'(ssr_pkg::SEGMENTS - 1);
   localparam logic [ssr_pkg::WIDE_W-1:0]  SEG_LIMIT =
      ssr_pkg::WIDE_W'(ssr_pkg::SEGMENTS);

   typedef enum logic {
      S_IDLE,
      S_COPY
   } state_type;

   state_type                        state_ff;
   logic                             out_valid_ff;
   logic [ssr_pkg::CNT_W-1:0]        count_ff;
   logic                             recv_ff;
   logic                             full_ff;
   logic                             dl_loaded_ff;
   logic [ssr_pkg::SEGMENTS-1:0]     work_valid_ff;
   logic [ssr_pkg::SWEEP_W-1:0]      sweep_ff;
   logic                             copy_wr_ff;
   logic [ssr_pkg::IDX_W-1:0]        copy_addr_ff;
   logic                             respond_ff;
   logic [ssr_pkg::ID_W-1:0]         id_ff;
   logic [ssr_pkg::CODE_W-1:0]       code_ff;
   logic                             read_ok_ff;

   // buffer memories
   logic [ssr_pkg::WORD_W-1:0]       work_mem_ff [ssr_pkg::SEGMENTS];
   logic [ssr_pkg::WORD_W-1:0]       dl_mem_ff   [ssr_pkg::SEGMENTS];
   logic [ssr_pkg::WORD_W-1:0]       work_rdata_ff;
   logic                             work_rvalid_ff;
   logic [ssr_pkg::WORD_W-1:0]       dl_rdata_ff;

   logic                             take;
   logic [ssr_pkg::WIDE_W-1:0]       seq_w;
   logic [ssr_pkg::WIDE_W-1:0]       next_w;
   logic                             seg_skip;
   logic                             seg_in_order;
   logic                             seg_store;
   logic                             seg_wipe;
   logic                             seg_last;
   logic [ssr_pkg::IDX_W-1:0]        seq_idx;
   logic                             rd_in_range;
   logic [ssr_pkg::IDX_W-1:0]        rd_idx;
   logic                             work_we;
   logic                             dl_re;
   logic                             sweep_rd;
   logic [ssr_pkg::IDX_W-1:0]        sweep_idx;

   // one command at a time, only with the response slot empty
   assign take      = (state_ff == S_IDLE) && cmd_valid && !out_valid_ff;
   assign cmd_ready = take;

   // segment rule decode
   always_comb begin
      seq_w        = ssr_pkg::WIDE_W'(cmd.seq);
      next_w       = ssr_pkg::WIDE_W'(count_ff) + 1'b1;
      seg_skip     = seq_w > next_w;
      seg_in_order = ((cmd.seq == '0) && (count_ff == '0)) || (seq_w == next_w);
      seg_store    = !seg_skip && !full_ff && seg_in_order;
      seg_wipe     = seg_skip || (!full_ff && !seg_in_order);
      seg_last     = (seq_w == LAST_SEQ);
      seq_idx      = ssr_pkg::IDX_W'(cmd.seq);
      rd_in_range  = ssr_pkg::WIDE_W'(cmd.word_index) < SEG_LIMIT;
      rd_idx       = ssr_pkg::IDX_W'(cmd.word_index);
   end

   assign work_we   = take && (cmd.op == ssr_pkg::OP_SEGMENT) && seg_store;
   assign dl_re     = take && (cmd.op == ssr_pkg::OP_READ) && rd_in_range;
   assign sweep_rd  = (state_ff == S_COPY) && (sweep_ff != SWEEP_END);
   assign sweep_idx = sweep_ff[ssr_pkg::IDX_W-1:0];

   // sequencer, flags and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         out_valid_ff  <= 1'b0;
         count_ff      <= '0;
         recv_ff       <= 1'b0;
         full_ff       <= 1'b0;
         dl_loaded_ff  <= 1'b0;
         work_valid_ff <= '0;
         sweep_ff      <= '0;
         copy_wr_ff    <= 1'b0;
      end else begin
         copy_wr_ff <= 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  respond_ff <= 1'b0;
                  id_ff      <= '0;
                  code_ff    <= '0;
                  read_ok_ff <= 1'b0;
                  unique case (cmd.op)
                     ssr_pkg::OP_SEGMENT: begin
                        if (seg_store) begin
                           work_valid_ff[seq_idx] <= 1'b1;
                           if (seg_last) begin
                              // packet complete: start the copy sweep
                              count_ff   <= '0;
                              recv_ff    <= 1'b0;
                              full_ff    <= 1'b1;
                              respond_ff <= 1'b1;
                              id_ff      <= cmd.requester;
                              code_ff    <= cmd.seq;
                              sweep_ff   <= '0;
                              state_ff   <= S_COPY;
                           end else begin
                              count_ff     <= ssr_pkg::CNT_W'(cmd.seq);
                              recv_ff      <= 1'b1;
                              out_valid_ff <= 1'b1;
                           end
                        end else begin
                           // abandon the packet
                           count_ff     <= '0;
                           recv_ff      <= 1'b0;
                           respond_ff   <= 1'b1;
                           id_ff        <= cmd.requester;
                           code_ff      <= ssr_pkg::FAIL_CODE;
                           out_valid_ff <= 1'b1;
                           if (seg_wipe) begin
                              work_valid_ff <= '0;
                           end
                        end
                     end
                     ssr_pkg::OP_READ: begin
                        read_ok_ff   <= rd_in_range && dl_loaded_ff;
                        out_valid_ff <= 1'b1;
                     end
                     ssr_pkg::OP_RELEASE: begin
                        full_ff      <= 1'b0;
                        out_valid_ff <= 1'b1;
                     end
                     ssr_pkg::OP_NOP: begin
                        out_valid_ff <= 1'b1;
                     end
                     default: begin
                        out_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_COPY: begin
               if (sweep_ff == SWEEP_END) begin
                  // last word lands at this edge
                  dl_loaded_ff <= 1'b1;
                  out_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  copy_wr_ff   <= 1'b1;
                  copy_addr_ff <= sweep_idx;
                  sweep_ff     <= sweep_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // working buffer: segment write port, sweep read port
   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem_ff[seq_idx] <= cmd.word;
      end
      if (sweep_rd) begin
         work_rdata_ff  <= work_mem_ff[sweep_idx];
         work_rvalid_ff <= work_valid_ff[sweep_idx];
      end
   end

   // downlink buffer: sweep write port, word read port
   always_ff @(posedge clock) begin
      if (copy_wr_ff) begin
         dl_mem_ff[copy_addr_ff] <= work_rvalid_ff ? work_rdata_ff : '0;
      end
      if (dl_re) begin
         dl_rdata_ff <= dl_mem_ff[rd_idx];
      end
   end

   // response channel
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.respond      = respond_ff;
   assign rsp_if.responder_id = id_ff;
   assign rsp_if.resp_code    = code_ff;
   assign rsp_if.receiving    = recv_ff;
   assign rsp_if.buffer_full  = full_ff;
   assign rsp_if.read_word    = read_ok_ff ? dl_rdata_ff : '0;

endmodule

// File: design/sequenced_segment_reassembler.sv
// top level of the sequenced segment reassembler
`timescale 1ns / 1ps

// Rebuilds a packet of 32 four-byte segments that must arrive in order from
// number 0; every request transaction gives exactly one response transaction.
// A front stage registers and classifies each request and a two-entry command
// queue hands it to the back stage, so requests keep flowing while a response
// waits. The back stage handles one command at a time. The final segment
// starts a sweep that copies the working buffer into the downlink buffer one
// word per cycle through the buffers' separate read and write ports, and its
// response is given once the sweep is done. A skip ahead, or any other
// sequence error while the downlink buffer is not full, wipes the working
// buffer by clearing its per-word valid bits; both buffers read as zero after
// reset with no clearing pass.

module sequenced_segment_reassembler (
   input  logic       clock,
   input  logic       reset,
   ssr_req_if.sink    req_if,
   ssr_rsp_if.source  rsp_if
);

   logic             front_valid;
   logic             front_ready;
   ssr_pkg::cmd_type front_cmd;
   logic             back_valid;
   logic             back_ready;
   ssr_pkg::cmd_type back_cmd;

   // accept and classify
   ssr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   // decoupling queue
   ssr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   // execute and respond
   ssr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_if    (rsp_if)
   );

endmodule

// File: design/ssr_checker.sv
// port-level checks of the reassembler and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          respond,
   input logic [ssr_pkg::ID_W-1:0]      responder_id,
   input logic [ssr_pkg::CODE_W-1:0]    resp_code,
   input logic                          receiving,
   input logic                          buffer_full,
   input logic [ssr_pkg::WORD_W-1:0]    read_word
);

   // no response transaction straight out of reset
   `SSR_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "response after reset")

   // a silent response carries no id and no code
   `SSR_ASSERT(a_silent_zero, clock, reset, (rsp_valid && !respond) |-> ((resp_code == '0) && (responder_id == '0)), "silent response with id or code")

   // a packet is never partly received while the downlink buffer is full
   `SSR_ASSERT(a_recv_full_excl, clock, reset, rsp_valid |-> !(receiving && buffer_full), "receiving while buffer full")

   // a completion code comes with a full buffer and no packet in progress
   `SSR_ASSERT(a_done_full, clock, reset, (rsp_valid && respond && (resp_code != ssr_pkg::FAIL_CODE)) |-> (buffer_full && !receiving), "completion without full buffer")

   // a stalled response holds
   `SSR_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(resp_code) && $stable(read_word)), "stalled response changed")

endmodule

bind sequenced_segment_reassembler ssr_checker u_ssr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .respond      (rsp_if.respond),
   .responder_id (rsp_if.responder_id),
   .resp_code    (rsp_if.resp_code),
   .receiving    (rsp_if.receiving),
   .buffer_full  (rsp_if.buffer_full),
   .read_word    (rsp_if.read_word)
);

// File: tb/tb_sequenced_segment_reassembler.sv
// self-checking testbench of the sequenced segment reassembler
`timescale 1ns / 1ps

module tb_sequenced_segment_reassembler;

   localparam logic [ssr_pkg::KIND_W-1:0] KIND_UNUSED = ssr_pkg::KIND_W'(3);

   localparam int ITEM_TARGET  = 1600;
   localparam int IDLE_PERCENT = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_PRINTED  = 100;

   typedef struct {
      logic [ssr_pkg::KIND_W-1:0]                                 kind;
      logic [ssr_pkg::ID_W-1:0]                                   requester;
      logic [ssr_pkg::SEQ_W-1:0]                                  seq;
      logic [ssr_pkg::BYTES_PER_SEGMENT-1:0][ssr_pkg::BYTE_W-1:0] payload;
      logic [ssr_pkg::WIX_W-1:0]                                  word_index;
   } seg_request_type;

   typedef struct {
      logic                       respond;
      logic [ssr_pkg::ID_W-1:0]   responder_id;
      logic [ssr_pkg::CODE_W-1:0] resp_code;
      logic                       receiving;
      logic                       buffer_full;
      logic [ssr_pkg::WORD_W-1:0] read_word;
   } seg_reply_type;

   logic clock;
   logic reset;

   ssr_req_if req_ch ();
   ssr_rsp_if rsp_ch ();

   sequenced_segment_reassembler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // mirror of the reassembly state
   logic [ssr_pkg::WORD_W-1:0] staged_words   [ssr_pkg::SEGMENTS] = '{default: '0};
   logic [ssr_pkg::WORD_W-1:0] downlink_words [ssr_pkg::SEGMENTS] = '{default: '0};
   int                         last_seq      = 0;
   bit                         in_packet     = 1'b0;
   bit                         downlink_held = 1'b0;

   seg_reply_type pending_replies [$];
   int            items_sent       = 0;
   int            error_count      = 0;
   bit            idle_on          = 1'b1;
   bit            hold_off_request = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [ssr_pkg::WORD_W-1:0] got,
                              input logic [ssr_pkg::WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // abandon the packet in progress, optionally wiping the staged words
   function automatic void drop_packet(input bit wipe);
      last_seq  = 0;
      in_packet = 1'b0;
      if (wipe)
         foreach (staged_words[i]) staged_words[i] = '0;
   endfunction

   // advance the mirrored state by one request and return its response
   function automatic seg_reply_type reassemble(input seg_request_type rq);
      seg_reply_type rp;
      int            next_seq;
      rp       = '{default: '0};
      next_seq = last_seq + 1;
      case (rq.kind)
         ssr_pkg::KIND_SEGMENT: begin
            if (int'(rq.seq) > next_seq) begin
               // skip ahead wipes even while the downlink is held
               rp.respond   = 1'b1;
               rp.resp_code = ssr_pkg::FAIL_CODE;
               drop_packet(1'b1);
            end else if (downlink_held) begin
               rp.respond   = 1'b1;
               rp.resp_code = ssr_pkg::FAIL_CODE;
               drop_packet(1'b0);
            end else if ((rq.seq == 0 && last_seq == 0) || int'(rq.seq) == next_seq) begin
               staged_words[rq.seq[ssr_pkg::IDX_W-1:0]] = rq.payload;
               last_seq  = int'(rq.seq);
               in_packet = 1'b1;
               // final segment hands the packet to the downlink
               if (int'(rq.seq) == ssr_pkg::SEGMENTS - 1) begin
                  last_seq       = 0;
                  in_packet      = 1'b0;
                  downlink_held  = 1'b1;
                  downlink_words = staged_words;
                  rp.respond     = 1'b1;
                  rp.resp_code   = rq.seq;
               end
            end else begin
               // repeat or step back
               rp.respond   = 1'b1;
               rp.resp_code = ssr_pkg::FAIL_CODE;
               drop_packet(1'b1);
            end
         end
         ssr_pkg::KIND_READ: begin
            if (int'(rq.word_index) < ssr_pkg::SEGMENTS)
               rp.read_word = downlink_words[rq.word_index];
         end
         ssr_pkg::KIND_RELEASE: begin
            downlink_held = 1'b0;
         end
         default: ;
      endcase
      rp.responder_id = rp.respond ? rq.requester : '0;
      rp.receiving    = in_packet;
      rp.buffer_full  = downlink_held;
      return rp;
   endfunction

   function automatic seg_request_type random_item(input logic [ssr_pkg::KIND_W-1:0] kind);
      seg_request_type rq;
      rq.kind       = kind;
      rq.requester  = ssr_pkg::ID_W'($urandom);
      rq.seq        = ssr_pkg::SEQ_W'($urandom);
      rq.payload    = $urandom;
      rq.word_index = ssr_pkg::WIX_W'($urandom);
      return rq;
   endfunction

   // offer one request, wait for acceptance, then record its response
   task automatic send_item(input seg_request_type rq);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= rq.kind;
      req_ch.requester  <= rq.requester;
      req_ch.seq        <= rq.seq;
      req_ch.byte0      <= rq.payload[0];
      req_ch.byte1      <= rq.payload[1];
      req_ch.byte2      <= rq.payload[2];
      req_ch.byte3      <= rq.payload[3];
      req_ch.word_index <= rq.word_index;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_replies.push_back(reassemble(rq));
      items_sent++;
   endtask

   task automatic send_segment(input int seq_no);
      seg_request_type rq;
      rq     = random_item(ssr_pkg::KIND_SEGMENT);
      rq.seq = ssr_pkg::SEQ_W'(seq_no);
      send_item(rq);
   endtask

   task automatic send_read(input int idx);
      seg_request_type rq;
      rq            = random_item(ssr_pkg::KIND_READ);
      rq.word_index = ssr_pkg::WIX_W'(idx);
      send_item(rq);
   endtask

   task automatic send_release();
      send_item(random_item(ssr_pkg::KIND_RELEASE));
   endtask

   // one well-formed packet with random payload
   task automatic send_packet();
      for (int i = 0; i < ssr_pkg::SEGMENTS; i++) send_segment(i);
   endtask

   // extremes, every kind and every sequence rule
   task automatic test_directed();
      seg_request_type rq;
      send_read(0);
      send_read(ssr_pkg::SEGMENTS - 1);
      send_release();
      send_item(random_item(KIND_UNUSED));
      // segment zero twice in a row is accepted both times
      rq           = random_item(ssr_pkg::KIND_SEGMENT);
      rq.seq       = '0;
      rq.requester = '1;
      rq.payload   = '1;
      send_item(rq);
      rq.requester = '0;
      rq.payload   = '0;
      send_item(rq);
      // repeated number
      send_segment(1);
      send_segment(1);
      // skip ahead
      send_segment(0);
      send_segment(2);
      // step back
      send_segment(0);
      send_segment(1);
      send_segment(0);
      // largest number
      send_segment(255);
      // final number too early
      send_segment(0);
      send_segment(1);
      send_segment(2);
      send_segment(ssr_pkg::SEGMENTS - 1);
      send_read(5);
   endtask

   // completion, readback and segments against a held downlink
   task automatic test_full_packet();
      send_packet();
      for (int i = 0; i < ssr_pkg::SEGMENTS; i++) send_read(i);
      send_segment(0);
      send_segment(1);
      send_segment(7);
      send_release();
      send_release();
      send_packet();
      for (int i = 0; i < 8; i++) send_read(int'($urandom_range(0, ssr_pkg::SEGMENTS - 1)));
      send_release();
   endtask

   // receiver holds off while a whole packet is offered
   task automatic test_backpressure();
      hold_off_request = 1'b1;
      send_packet();
      for (int i = 0; i < 8; i++) send_read(int'($urandom_range(0, ssr_pkg::SEGMENTS - 1)));
      send_release();
   endtask

   // mostly well-formed packets, with reads, releases and noise mixed in
   task automatic test_random_traffic();
      int pick;
      int seg;
      bit broken;
      while (items_sent < ITEM_TARGET) begin
         // long stretch with no idling on either side
         idle_on = !(items_sent >= 700 && items_sent < 1000);
         pick    = int'($urandom_range(0, 99));
         if (pick < 60) begin
            if (downlink_held && $urandom_range(0, 9) < 8) send_release();
            seg    = 0;
            broken = 1'b0;
            while (seg < ssr_pkg::SEGMENTS && !broken) begin
               if ($urandom_range(0, 99) < 4)
                  send_read(int'($urandom_range(0, ssr_pkg::SEGMENTS - 1)));
               if ($urandom_range(0, 99) < 1) begin
                  send_segment(int'($urandom_range(0, 255)));
                  broken = 1'b1;
               end else begin
                  send_segment(seg);
               end
               seg++;
            end
         end else if (pick < 75) begin
            send_read(int'($urandom_range(0, ssr_pkg::SEGMENTS - 1)));
         end else if (pick < 85) begin
            send_release();
         end else if (pick < 95) begin
            if ($urandom_range(0, 1)) send_segment(last_seq + int'($urandom_range(0, 2)));
            else send_segment(int'($urandom_range(0, 255)));
         end else begin
            send_item(random_item(KIND_UNUSED));
         end
      end
   endtask

   // response ready with random stalls and an on-demand long hold
   initial begin : reply_ready_driver
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_left        = HOLD_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (idle_on) begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin : reply_checker
      seg_reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("response transaction with none outstanding");
         end else begin
            want = pending_replies.pop_front();
            check_field("respond", ssr_pkg::WORD_W'(rsp_ch.respond),
                        ssr_pkg::WORD_W'(want.respond));
            check_field("responder_id", ssr_pkg::WORD_W'(rsp_ch.responder_id),
                        ssr_pkg::WORD_W'(want.responder_id));
            check_field("resp_code", ssr_pkg::WORD_W'(rsp_ch.resp_code),
                        ssr_pkg::WORD_W'(want.resp_code));
            check_field("receiving", ssr_pkg::WORD_W'(rsp_ch.receiving),
                        ssr_pkg::WORD_W'(want.receiving));
            check_field("buffer_full", ssr_pkg::WORD_W'(rsp_ch.buffer_full),
                        ssr_pkg::WORD_W'(want.buffer_full));
            check_field("read_word", rsp_ch.read_word, want.read_word);
         end
      end
   end

   // end the run when no transaction moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                   || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // reset, test sequence and final verdict
   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= '0;
      req_ch.requester  <= '0;
      req_ch.seq        <= '0;
      req_ch.byte0      <= '0;
      req_ch.byte1      <= '0;
      req_ch.byte2      <= '0;
      req_ch.byte3      <= '0;
      req_ch.word_index <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_packet();
      test_backpressure();
      test_random_traffic();
      req_ch.valid <= 1'b0;

      // drain outstanding responses, then let the block settle
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
